@@ hw/rtl/awi_pkg.sv @@
package awi_pkg;

	localparam int COORD_W = 12;
	localparam int SIZE_W  = 16;
	localparam int PIX_W   = 24;

	typedef enum logic [1:0] {
		MODE_LOAD     = 2'd0,
		MODE_NEAREST  = 2'd1,
		MODE_BILINEAR = 2'd2,
		MODE_RSVD     = 2'd3
	} mode_t;

	localparam logic [2:0] REG_COEF_ROW_ROW = 3'd0;
	localparam logic [2:0] REG_COEF_ROW_COL = 3'd1;
	localparam logic [2:0] REG_OFFSET_ROW   = 3'd2;
	localparam logic [2:0] REG_COEF_COL_ROW = 3'd3;
	localparam logic [2:0] REG_COEF_COL_COL = 3'd4;
	localparam logic [2:0] REG_OFFSET_COL   = 3'd5;
	localparam logic [2:0] REG_SOURCE_ROWS  = 3'd6;
	localparam logic [2:0] REG_SOURCE_COLS  = 3'd7;

	typedef struct packed {
		logic [31:0] coef_row_row;
		logic [31:0] coef_row_col;
		logic [31:0] offset_row;
		logic [31:0] coef_col_row;
		logic [31:0] coef_col_col;
		logic [31:0] offset_col;
	} matrix_t;

	typedef struct packed {
		logic               is_map;
		logic               in_src;
		logic               wr_ok;
		logic [COORD_W-1:0] ra;
		logic [COORD_W-1:0] rb;
		logic [COORD_W-1:0] ca;
		logic [COORD_W-1:0] cb;
		logic [15:0]        fa;
		logic [15:0]        fb;
		logic [PIX_W-1:0]   px;
	} coord_t;

	typedef struct packed {
		logic        in_src;
		logic        ra0;
		logic        rb0;
		logic        ca0;
		logic        cb0;
		logic [15:0] fa;
		logic [15:0] fb;
	} fetch_t;

	typedef struct packed {
		logic       in_src;
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic [7:0] ch2;
	} result_t;

endpackage

@@ hw/rtl/awi_if.sv @@
interface awi_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [8:0] row;
	logic [8:0] col;
	logic [7:0] in_ch0;
	logic [7:0] in_ch1;
	logic [7:0] in_ch2;
	modport source(output valid, mode, row, col, in_ch0, in_ch1, in_ch2, input ready);
	modport sink(input valid, mode, row, col, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface awi_result_if;
	logic       valid;
	logic       ready;
	logic       inside_res;
	logic [7:0] out_ch0;
	logic [7:0] out_ch1;
	logic [7:0] out_ch2;
	modport source(output valid, inside_res, out_ch0, out_ch1, out_ch2, input ready);
	modport sink(input valid, inside_res, out_ch0, out_ch1, out_ch2, output ready);
endinterface

interface awi_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/awi_ram.sv @@
module awi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/awi_map.sv @@
module awi_map #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_COLS = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [1:0]                  mode,
	input  logic [8:0]                  row,
	input  logic [8:0]                  col,
	input  logic [awi_pkg::PIX_W-1:0]   px,
	input  awi_pkg::matrix_t            mat,
	input  logic [awi_pkg::SIZE_W-1:0]  rows_lim,
	input  logic [awi_pkg::SIZE_W-1:0]  cols_lim,
	output logic                        v_s3,
	output awi_pkg::coord_t             c_s3
);
	import awi_pkg::*;

	logic               v_s1, v_s2;
	mode_t              mode_s1, mode_s2;
	logic [8:0]         row_s1, col_s1, row_s2, col_s2;
	logic [PIX_W-1:0]   px_s1, px_s2;
	logic signed [41:0] p_rr_s1, p_rc_s1, p_cr_s1, p_cc_s1;
	logic signed [43:0] sr_s2, sc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && (mode_t'(mode) != MODE_RSVD);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_t'(mode);
			row_s1  <= row;
			col_s1  <= col;
			px_s1   <= px;
			p_rr_s1 <= $signed(mat.coef_row_row) * $signed({1'b0, row});
			p_rc_s1 <= $signed(mat.coef_row_col) * $signed({1'b0, col});
			p_cr_s1 <= $signed(mat.coef_col_row) * $signed({1'b0, row});
			p_cc_s1 <= $signed(mat.coef_col_col) * $signed({1'b0, col});
			mode_s2 <= mode_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			px_s2   <= px_s1;
			sr_s2   <= 44'(p_rr_s1) + 44'(p_rc_s1) + 44'($signed(mat.offset_row));
			sc_s2   <= 44'(p_cr_s1) + 44'(p_cc_s1) + 44'($signed(mat.offset_col));
		end
	end

	logic signed [43:0] tr, tc;
	logic               in_r, in_c;
	logic [15:0]        fl_r, fl_c, ra16, ca16, rb16, cb16, rbc, cbc;
	logic               bil;
	coord_t             c_d;

	always_comb begin
		tr   = sr_s2 + 44'sd32768;
		tc   = sc_s2 + 44'sd32768;
		in_r = !tr[43] && (tr != 44'sd0) && (tr[43:16] < {12'd0, rows_lim});
		in_c = !tc[43] && (tc != 44'sd0) && (tc[43:16] < {12'd0, cols_lim});
		fl_r = sr_s2[31:16];
		fl_c = sc_s2[31:16];
		ra16 = fl_r[15] ? 16'd0 : fl_r;
		ca16 = fl_c[15] ? 16'd0 : fl_c;
		rbc  = fl_r + 16'd1;
		cbc  = fl_c + 16'd1;
		rb16 = (rbc >= rows_lim) ? rows_lim - 16'd1 : rbc;
		cb16 = (cbc >= cols_lim) ? cols_lim - 16'd1 : cbc;
		bil  = (mode_s2 == MODE_BILINEAR);

		c_d.is_map = (mode_s2 != MODE_LOAD);
		c_d.in_src = in_r && in_c;
		c_d.wr_ok  = (32'(row_s2) < 32'(MAX_ROWS)) && (32'(col_s2) < 32'(MAX_COLS));
		c_d.px     = px_s2;
		if (mode_s2 == MODE_LOAD) begin
			c_d.ra = COORD_W'(row_s2);
			c_d.rb = COORD_W'(row_s2);
			c_d.ca = COORD_W'(col_s2);
			c_d.cb = COORD_W'(col_s2);
			c_d.fa = 16'd0;
			c_d.fb = 16'd0;
		end else begin
			c_d.ra = ra16[COORD_W-1:0];
			c_d.ca = ca16[COORD_W-1:0];
			c_d.rb = bil ? rb16[COORD_W-1:0] : ra16[COORD_W-1:0];
			c_d.cb = bil ? cb16[COORD_W-1:0] : ca16[COORD_W-1:0];
			c_d.fa = bil ? sr_s2[15:0] : 16'd0;
			c_d.fb = bil ? sc_s2[15:0] : 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3 <= c_d;
		end
	end

endmodule

@@ hw/rtl/awi_blend.sv @@
module awi_blend #(
	parameter int CHANNELS = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       v_s4,
	input  awi_pkg::fetch_t            f_s4,
	input  logic [awi_pkg::PIX_W-1:0]  bank_rd [4],
	output logic                       v_s7,
	output awi_pkg::result_t           r_s7
);
	import awi_pkg::*;

	logic             v_s5, v_s6;
	logic             inside_s5, inside_s6;
	logic [32:0]      w_s5 [4];
	logic [PIX_W-1:0] p_s5 [4];
	logic [40:0]      prod_s6 [3][4];
	logic [16:0]      na, nb;
	logic [33:0]      w_d [4];
	logic [PIX_W-1:0] p_d [4];

	always_comb begin
		na     = 17'd65536 - {1'b0, f_s4.fa};
		nb     = 17'd65536 - {1'b0, f_s4.fb};
		w_d[0] = na * nb;
		w_d[1] = {1'b0, f_s4.fa} * nb;
		w_d[2] = na * {1'b0, f_s4.fb};
		w_d[3] = {1'b0, f_s4.fa} * {1'b0, f_s4.fb};
		p_d[0] = bank_rd[{f_s4.ra0, f_s4.ca0}];
		p_d[1] = bank_rd[{f_s4.rb0, f_s4.ca0}];
		p_d[2] = bank_rd[{f_s4.ra0, f_s4.cb0}];
		p_d[3] = bank_rd[{f_s4.rb0, f_s4.cb0}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s5 <= f_s4.in_src;
			inside_s6 <= inside_s5;
			for (int j = 0; j < 4; j++) begin
				w_s5[j] <= w_d[j][32:0];
				p_s5[j] <= p_d[j];
			end
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s6[k][j] <= w_s5[j] * p_s5[j][8*k +: 8];
				end
			end
		end
	end

	logic [42:0] acc [3];
	logic [7:0]  ch [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = 43'(prod_s6[k][0]) + 43'(prod_s6[k][1]) + 43'(prod_s6[k][2])
				+ 43'(prod_s6[k][3]) + 43'h0_8000_0000;
			ch[k]  = (acc[k][42:32] > 11'd255) ? 8'hff : acc[k][39:32];
			if (!inside_s6 || k >= CHANNELS) begin
				ch[k] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s7.in_src <= inside_s6;
			r_s7.ch0    <= ch[0];
			r_s7.ch1    <= ch[1];
			r_s7.ch2    <= ch[2];
		end
	end

endmodule

@@ hw/rtl/affine_warp_interpolate.sv @@
// An accepted map beat passes the map, bank read and blend stages to its result.
// Throughput: one beat per cycle while results are taken; the image store is
// four parity banks, so the four bilinear neighbors are read together.
// A stalled result beat holds the whole pipeline.
// Reset: asynchronous active low; clears valid bits and loads register defaults.
// The image store is not cleared.
module affine_warp_interpolate #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_COLS = 512,
	parameter int CHANNELS = 3
) (
	input logic         clk,
	input logic         arst_n,
	awi_item_if.sink    item,
	awi_result_if.source result,
	awi_cfg_if.sink     cfg
);
	import awi_pkg::*;

	localparam int HR = (MAX_ROWS + 1) / 2;
	localparam int HC = (MAX_COLS + 1) / 2;
	localparam int BD = HR * HC;
	localparam int AW = BD > 1 ? $clog2(BD) : 1;

	matrix_t           mat_q;
	logic [9:0]        rows_q, cols_q;
	logic [SIZE_W-1:0] rows_lim, cols_lim;
	logic              adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q.coef_row_row <= 32'd65536;
			mat_q.coef_row_col <= 32'd0;
			mat_q.offset_row   <= 32'd0;
			mat_q.coef_col_row <= 32'd0;
			mat_q.coef_col_col <= 32'd65536;
			mat_q.offset_col   <= 32'd0;
			rows_q             <= 10'd512;
			cols_q             <= 10'd512;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COEF_ROW_ROW: mat_q.coef_row_row <= cfg.data;
				REG_COEF_ROW_COL: mat_q.coef_row_col <= cfg.data;
				REG_OFFSET_ROW:   mat_q.offset_row   <= cfg.data;
				REG_COEF_COL_ROW: mat_q.coef_col_row <= cfg.data;
				REG_COEF_COL_COL: mat_q.coef_col_col <= cfg.data;
				REG_OFFSET_COL:   mat_q.offset_col   <= cfg.data;
				REG_SOURCE_ROWS:  rows_q             <= cfg.data[9:0];
				REG_SOURCE_COLS:  cols_q             <= cfg.data[9:0];
				default:          ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign rows_lim  = (32'(rows_q) > 32'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : SIZE_W'(rows_q);
	assign cols_lim  = (32'(cols_q) > 32'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : SIZE_W'(cols_q);

	logic   v_s7;
	assign adv        = !v_s7 || result.ready;
	assign item.ready = adv;

	logic   v_s3;
	coord_t c_s3;

	awi_map #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (item.valid),
		.mode     (item.mode),
		.row      (item.row),
		.col      (item.col),
		.px       ({item.in_ch2, item.in_ch1, item.in_ch0}),
		.mat      (mat_q),
		.rows_lim (rows_lim),
		.cols_lim (cols_lim),
		.v_s3     (v_s3),
		.c_s3     (c_s3)
	);

	logic [PIX_W-1:0] bank_rd [4];
	logic             is_load;
	assign is_load = v_s3 && !c_s3.is_map && c_s3.wr_ok;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [COORD_W-1:0] rs, cs;
		logic [AW-1:0]      addr;
		logic               we;
		assign rs   = (c_s3.ra[0] == b[1]) ? c_s3.ra : c_s3.rb;
		assign cs   = (c_s3.ca[0] == b[0]) ? c_s3.ca : c_s3.cb;
		assign addr = AW'(32'(rs[COORD_W-1:1]) * 32'(HC) + 32'(cs[COORD_W-1:1]));
		assign we   = adv && is_load && (c_s3.ra[0] == b[1]) && (c_s3.ca[0] == b[0]);

		awi_ram #(.WIDTH(PIX_W), .DEPTH(BD)) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (addr),
			.wdata (c_s3.px),
			.re    (adv),
			.raddr (addr),
			.rdata (bank_rd[b])
		);
	end

	logic   v_s4;
	fetch_t f_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3 && c_s3.is_map;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4.in_src <= c_s3.in_src;
			f_s4.ra0    <= c_s3.ra[0];
			f_s4.rb0    <= c_s3.rb[0];
			f_s4.ca0    <= c_s3.ca[0];
			f_s4.cb0    <= c_s3.cb[0];
			f_s4.fa     <= c_s3.fa;
			f_s4.fb     <= c_s3.fb;
		end
	end

	result_t r_s7;

	awi_blend #(.CHANNELS(CHANNELS)) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s4    (v_s4),
		.f_s4    (f_s4),
		.bank_rd (bank_rd),
		.v_s7    (v_s7),
		.r_s7    (r_s7)
	);

	assign result.valid      = v_s7;
	assign result.inside_res = r_s7.in_src;
	assign result.out_ch0    = r_s7.ch0;
	assign result.out_ch1    = r_s7.ch1;
	assign result.out_ch2    = r_s7.ch2;

endmodule

@@ bench/affine_warp_interpolate_tb.sv @@
module affine_warp_interpolate_tb;
	import awi_pkg::*;

	localparam int ROWS_MAX = 512;
	localparam int COLS_MAX = 512;
	localparam int PIPE_LAT = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	awi_item_if   item();
	awi_result_if result();
	awi_cfg_if    cfg();

	affine_warp_interpolate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg(cfg)
	);

	always #2 clk = ~clk;

	logic [31:0] mat [0:5];
	int          src_rows;
	int          src_cols;
	logic [23:0] pixels [int];
	result_t     pending_px [$];
	int          errors = 0;
	int          mismatches = 0;
	bit          calm = 1'b0;

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint round_half_away(longint v);
		if (v >= 0)
			return (v + 32768) >>> 16;
		return -((-v + 32768) >>> 16);
	endfunction

	function automatic int clip(longint v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic logic [23:0] fetch_px(int r, int c);
		return pixels.exists(r * COLS_MAX + c) ? pixels[r * COLS_MAX + c] : 24'd0;
	endfunction

	function automatic result_t warp_pixel(mode_t m, int r, int c);
		result_t     res;
		longint      sr, sc, rr, rc, ur, uc, a, b, acc;
		int          rows, cols, ra, rb, ca, cb;
		logic [23:0] p, p11, p21, p12, p22;
		longint      w11, w21, w12, w22;
		res = '0;
		rows = src_rows > ROWS_MAX ? ROWS_MAX : src_rows;
		cols = src_cols > COLS_MAX ? COLS_MAX : src_cols;
		sr = sx32(mat[0]) * r + sx32(mat[1]) * c + sx32(mat[2]);
		sc = sx32(mat[3]) * r + sx32(mat[4]) * c + sx32(mat[5]);
		rr = round_half_away(sr);
		rc = round_half_away(sc);
		if (!(rr >= 0 && rr < rows && rc >= 0 && rc < cols))
			return res;
		res.in_src = 1'b1;
		if (m == MODE_NEAREST) begin
			p = fetch_px(clip(sr > 0 ? sr >>> 16 : 0, rows - 1),
				clip(sc > 0 ? sc >>> 16 : 0, cols - 1));
			res.ch0 = p[7:0];
			res.ch1 = p[15:8];
			res.ch2 = p[23:16];
		end else begin
			ur = sr + 65536;
			uc = sc + 65536;
			a = ur & 16'hFFFF;
			b = uc & 16'hFFFF;
			ra = clip((ur >>> 16) - 1, rows - 1);
			rb = clip(ur >>> 16, rows - 1);
			ca = clip((uc >>> 16) - 1, cols - 1);
			cb = clip(uc >>> 16, cols - 1);
			p11 = fetch_px(ra, ca);
			p21 = fetch_px(rb, ca);
			p12 = fetch_px(ra, cb);
			p22 = fetch_px(rb, cb);
			w11 = (65536 - a) * (65536 - b);
			w21 = a * (65536 - b);
			w12 = (65536 - a) * b;
			w22 = a * b;
			for (int k = 0; k < 3; k++) begin
				acc = w11 * p11[8*k +: 8] + w21 * p21[8*k +: 8]
					+ w12 * p12[8*k +: 8] + w22 * p22[8*k +: 8] + 64'h80000000;
				acc = acc >>> 32;
				if (acc > 255)
					acc = 255;
				if (k == 0)
					res.ch0 = acc[7:0];
				else if (k == 1)
					res.ch1 = acc[7:0];
				else
					res.ch2 = acc[7:0];
			end
		end
		return res;
	endfunction

	function automatic bit gap();
		return !calm && $urandom_range(99) < 18;
	endfunction

	task automatic send_item(mode_t m, int r, int c, logic [23:0] px);
		while (gap()) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid <= 1'b1;
		item.mode <= m;
		item.row <= r[8:0];
		item.col <= c[8:0];
		item.in_ch0 <= px[7:0];
		item.in_ch1 <= px[15:8];
		item.in_ch2 <= px[23:16];
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		if (m == MODE_LOAD)
			pixels[r * COLS_MAX + c] = px;
		else if (m != MODE_RSVD)
			pending_px.push_back(warp_pixel(m, r, c));
		@(negedge clk);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (pending_px.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 3)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		if (idx < 3'd6)
			mat[idx] = v;
		else if (idx == REG_SOURCE_ROWS)
			src_rows = v[9:0];
		else
			src_cols = v[9:0];
		@(negedge clk);
	endtask

	task automatic set_warp(logic [31:0] rr, logic [31:0] rc, logic [31:0] ro,
		logic [31:0] cr, logic [31:0] cc, logic [31:0] co, int nr, int nc);
		drain();
		write_reg(REG_COEF_ROW_ROW, rr);
		write_reg(REG_COEF_ROW_COL, rc);
		write_reg(REG_OFFSET_ROW, ro);
		write_reg(REG_COEF_COL_ROW, cr);
		write_reg(REG_COEF_COL_COL, cc);
		write_reg(REG_OFFSET_COL, co);
		write_reg(REG_SOURCE_ROWS, nr);
		write_reg(REG_SOURCE_COLS, nc);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_px();
		return 24'($urandom);
	endfunction

	// fill the rows x cols corner so every reachable read hits written data
	task automatic load_block(int nr, int nc);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!pixels.exists(r * COLS_MAX + c))
					send_item(MODE_LOAD, r, c, rand_px());
	endtask

	always @(posedge clk) begin
		result_t got, want;
		if (result.valid && result.ready) begin
			got = '{result.inside_res, result.out_ch0, result.out_ch1, result.out_ch2};
			if (pending_px.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result beat %p", got);
			end else begin
				want = pending_px.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(negedge clk)
		result.ready <= arst_n && !gap();

	task automatic test_directed();
		int last = 511;
		load_block(5, 5);
		send_item(MODE_LOAD, last, last, 24'hFFFFFF);
		send_item(MODE_LOAD, last, 0, 24'h000000);
		send_item(MODE_LOAD, last, 1, 24'h3C3C3C);
		send_item(MODE_LOAD, 0, last, 24'hA5A5A5);
		send_item(MODE_LOAD, 1, last, 24'h5A5A5A);
		send_item(MODE_RSVD, 1, 1, 24'h123456);
		send_item(MODE_NEAREST, 0, 0, 0);
		send_item(MODE_BILINEAR, 3, 3, 0);
		send_item(MODE_NEAREST, last, last, 0);
		send_item(MODE_BILINEAR, last, 0, 0);
		send_item(MODE_BILINEAR, 0, last, 0);
		send_item(MODE_NEAREST, 4, 4, 0);
		set_warp(32'h8000, 0, 32'h8000, 0, 32'h8000, 32'hFFFF_C000, 4, 4);
		for (int i = 0; i < 10; i++)
			send_item(i % 2 ? MODE_BILINEAR : MODE_NEAREST, i, 9 - i, 0);
		set_warp(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0);
		send_item(MODE_NEAREST, 0, 0, 0);
		send_item(MODE_BILINEAR, 1, 1, 0);
		set_warp(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1023, 1023);
		send_item(MODE_NEAREST, 1, 1, 0);
		send_item(MODE_BILINEAR, 0, 0, 0);
		send_item(MODE_NEAREST, 0, 0, 0);
	endtask

	task automatic test_random_warps();
		int nr, nc, n;
		mode_t m;
		for (int phase = 0; phase < 8; phase++) begin
			nr = $urandom_range(1, 8);
			nc = $urandom_range(1, 8);
			if (phase == 7) begin
				nr = 512;
				nc = 512;
			end
			calm = (phase == 3);
			set_warp($urandom_range(0, 32'h18000) - 32'hC000, $urandom_range(0, 32'h8000) - 32'h4000,
				$urandom_range(0, 32'h40000) - 32'h20000,
				$urandom_range(0, 32'h8000) - 32'h4000, $urandom_range(0, 32'h18000) - 32'hC000,
				$urandom_range(0, 32'h40000) - 32'h20000, nr, nc);
			if (phase == 7)
				set_warp(32'h10000, 0, 32'h1F8_0000, 0, 32'h10000, 32'h1F8_0000, nr, nc);
			load_block(phase == 7 ? 0 : nr, phase == 7 ? 0 : nc);
			if (phase == 7) begin
				for (int r = 504; r < 512; r++)
					for (int c = 504; c < 512; c++)
						send_item(MODE_LOAD, r, c, rand_px());
			end
			n = 0;
			while (n < 100) begin
				m = mode_t'($urandom_range(1, 2));
				if ($urandom_range(9) == 0)
					m = mode_t'($urandom_range(0, 3) == 3 ? MODE_RSVD : MODE_LOAD);
				if (m == MODE_LOAD)
					send_item(m, $urandom_range(0, phase == 7 ? 511 : nr - 1),
						$urandom_range(0, phase == 7 ? 511 : nc - 1), rand_px());
				else
					send_item(m, $urandom_range(0, phase == 7 ? 7 : 10) + (phase == 7 ? 0 : 0),
						$urandom_range(0, phase == 7 ? 7 : 10), rand_px());
				if (m != MODE_RSVD)
					n++;
			end
			// rows, cols of 511 in a map item through the current warp
			send_item(MODE_NEAREST, 511, 511, 24'hFFFFFF);
		end
		calm = 1'b0;
	endtask

	initial begin
		item.valid = 1'b0;
		item.mode = MODE_LOAD;
		item.row = '0;
		item.col = '0;
		item.in_ch0 = '0;
		item.in_ch1 = '0;
		item.in_ch2 = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
		mat[0] = 32'h10000;
		mat[1] = 0;
		mat[2] = 0;
		mat[3] = 0;
		mat[4] = 32'h10000;
		mat[5] = 0;
		src_rows = 512;
		src_cols = 512;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_warps();
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
